FILE: sv/assert_macros.svh
// Assertion helpers shared by the allocator modules.
// Both expect clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge out of reset.
`define FFHA_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("allocator check failed");

// Check a plain condition on every clock edge out of reset.
`define FFHA_ASSERT_NOW(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("allocator invariant broken");

`endif

FILE: sv/ffha_pkg.sv
package ffha_pkg;

  // Field widths
  localparam int START_W = 22;
  localparam int SIZE_W  = 23;
  localparam int NEED_W  = 24;
  localparam int ADDR_W  = 48;
  localparam int BYTES_W = 23;
  localparam int STAT_W  = 2;
  localparam int CFG_W   = 64;
  localparam int PADDR_W = 4;

  // Rounding grain and split slack in bytes
  localparam int GRAIN       = 16;
  localparam int SPLIT_SLACK = 16;

  // Request kinds
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_OOM     = 2'd1;
  localparam logic [STAT_W-1:0] ST_ZERO    = 2'd2;
  localparam logic [STAT_W-1:0] ST_UNKNOWN = 2'd3;

  // Register index (paddr[3])
  localparam logic REG_HEAP_BASE = 1'b0;

  // Table read commands
  localparam logic [1:0] RD_NONE = 2'd0;
  localparam logic [1:0] RD_HEAD = 2'd1;
  localparam logic [1:0] RD_ADV  = 2'd2;
  localparam logic [1:0] RD_B    = 2'd3;

  // Table write commands
  localparam logic [2:0] WR_NONE    = 3'd0;
  localparam logic [2:0] WR_SPLIT   = 3'd1;
  localparam logic [2:0] WR_A_SPLIT = 3'd2;
  localparam logic [2:0] WR_GRANT   = 3'd3;
  localparam logic [2:0] WR_FREE    = 3'd4;
  localparam logic [2:0] WR_MERGE   = 3'd5;

  typedef struct packed {
    logic       load;
    logic [1:0] rd;
    logic       latch_a;
    logic       latch_b;
    logic       adv;
    logic [2:0] wr;
    logic       cap_addr;
    logic       out_load;
  } ffha_cmd_t;

  typedef struct packed {
    logic a_free;
    logic a_fits;
    logic split_ok;
    logic a_last;
    logic match;
    logic b_free;
    logic b_last;
  } ffha_sts_t;

endpackage

FILE: sv/ffha_req_if.sv
interface ffha_req_if import ffha_pkg::*;;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [BYTES_W-1:0] alloc_bytes;
  logic [ADDR_W-1:0]  free_address;

  modport source (output valid, req_type, alloc_bytes, free_address, input ready);
  modport sink   (input valid, req_type, alloc_bytes, free_address, output ready);
endinterface

FILE: sv/ffha_rsp_if.sv
interface ffha_rsp_if import ffha_pkg::*;;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [ADDR_W-1:0] payload_address;

  modport source (output valid, status, payload_address, input ready);
  modport sink   (input valid, status, payload_address, output ready);
endinterface

FILE: sv/ffha_dp.sv
`include "assert_macros.svh"

module ffha_dp import ffha_pkg::*; #(
  parameter int HEAP_BYTES   = 4194304,
  parameter int MAX_BLOCKS   = 256,
  parameter int HEADER_BYTES = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [ADDR_W-1:0]  heap_base_i,
  input  logic [BYTES_W-1:0] alloc_bytes_i,
  input  logic [ADDR_W-1:0]  free_address_i,
  input  ffha_cmd_t          cmd_i,
  output ffha_sts_t          sts_o,
  output logic [ADDR_W-1:0]  payload_address_o
);

  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int NXT_W = $clog2(MAX_BLOCKS + 1);
  localparam logic [NXT_W-1:0]  END_MARK = NXT_W'(MAX_BLOCKS);
  localparam logic [SIZE_W-1:0] HDR_SZ   = SIZE_W'(HEADER_BYTES);

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [SIZE_W-1:0]  size;
    logic               free;
    logic [NXT_W-1:0]   nxt;
  } ent_t;

  localparam ent_t INIT_WORD = '{start: '0, size: SIZE_W'(HEAP_BYTES - HEADER_BYTES),
                                 free: 1'b1, nxt: END_MARK};

  ent_t              mem_q [MAX_BLOCKS];
  logic [IDX_W-1:0]  stk_mem_q [MAX_BLOCKS];
  ent_t              rdata_q;
  logic              rd_head_q;
  logic              head_init_q;
  ent_t              a_q, b_q;
  logic [IDX_W-1:0]  cur_q, idx_b_q, sp_q, stk_top_q;
  logic [NXT_W-1:0]  stk_cnt_q, hwm_q;
  logic [NEED_W-1:0] need_q;
  logic [ADDR_W-1:0] target_q, pend_addr_q, out_addr_q;

  ent_t              rd_word, wr_data;
  logic              rd_en, wr_en, spare_ok, hwm_room;
  logic [IDX_W-1:0]  rd_idx, wr_idx, spare_idx, top_idx;
  logic [NEED_W-1:0] rest;
  logic [ADDR_W-1:0] a_payload;

  // Status toward the controller
  assign rd_word   = rd_head_q ? INIT_WORD : rdata_q;
  assign a_payload = heap_base_i + ADDR_W'(a_q.start) + ADDR_W'(HEADER_BYTES);
  assign rest      = NEED_W'(a_q.size) - need_q;
  assign hwm_room  = hwm_q < END_MARK;
  assign spare_ok  = hwm_room || (stk_cnt_q != '0);
  assign spare_idx = hwm_room ? hwm_q[IDX_W-1:0] : stk_top_q;
  assign top_idx   = IDX_W'(stk_cnt_q - NXT_W'(1));

  always_comb begin
    sts_o.a_free   = a_q.free;
    sts_o.a_fits   = NEED_W'(a_q.size) >= need_q;
    sts_o.split_ok = (rest > NEED_W'(HEADER_BYTES + SPLIT_SLACK)) && spare_ok;
    sts_o.a_last   = a_q.nxt == END_MARK;
    sts_o.match    = a_payload == target_q;
    sts_o.b_free   = b_q.free;
    sts_o.b_last   = b_q.nxt == END_MARK;
  end

  // Table read address
  always_comb begin
    rd_en  = 1'b1;
    rd_idx = '0;
    case (cmd_i.rd)
      RD_HEAD: rd_idx = '0;
      RD_ADV:  rd_idx = a_q.nxt[IDX_W-1:0];
      RD_B:    rd_idx = a_q.nxt[IDX_W-1:0];
      default: rd_en  = 1'b0;
    endcase
  end

  // Table write address and data
  always_comb begin
    wr_en   = 1'b1;
    wr_idx  = cur_q;
    wr_data = a_q;
    case (cmd_i.wr)
      WR_SPLIT: begin
        wr_idx        = spare_idx;
        wr_data.start = a_q.start + START_W'(HEADER_BYTES) + need_q[START_W-1:0];
        wr_data.size  = rest[SIZE_W-1:0] - HDR_SZ;
        wr_data.free  = 1'b1;
      end
      WR_A_SPLIT: begin
        wr_data.size = need_q[SIZE_W-1:0];
        wr_data.free = 1'b0;
        wr_data.nxt  = NXT_W'(sp_q);
      end
      WR_GRANT: wr_data.free = 1'b0;
      WR_FREE:  wr_data.free = 1'b1;
      WR_MERGE: begin
        wr_data.size = a_q.size + HDR_SZ + b_q.size;
        wr_data.nxt  = b_q.nxt;
      end
      default: wr_en = 1'b0;
    endcase
  end

  // Block table and recycled-entry stack
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_idx];
    end
    if (cmd_i.wr == WR_MERGE) begin
      stk_mem_q[stk_cnt_q[IDX_W-1:0]] <= idx_b_q;
    end
    stk_top_q <= stk_mem_q[top_idx];
  end

  // Entry bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_init_q <= 1'b1;
      rd_head_q   <= 1'b0;
      stk_cnt_q   <= '0;
      hwm_q       <= NXT_W'(1);
    end else begin
      if (rd_en) begin
        rd_head_q <= head_init_q && (rd_idx == '0);
      end
      if (wr_en && (wr_idx == '0)) begin
        head_init_q <= 1'b0;
      end
      if (cmd_i.wr == WR_MERGE) begin
        stk_cnt_q <= stk_cnt_q + NXT_W'(1);
      end else if (cmd_i.wr == WR_SPLIT) begin
        if (hwm_room) begin
          hwm_q <= hwm_q + NXT_W'(1);
        end else begin
          stk_cnt_q <= stk_cnt_q - NXT_W'(1);
        end
      end
    end
  end

  // Walk registers and request payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      need_q      <= (NEED_W'(alloc_bytes_i) + NEED_W'(GRAIN - 1)) & ~NEED_W'(GRAIN - 1);
      target_q    <= free_address_i;
      pend_addr_q <= '0;
    end
    if (cmd_i.rd == RD_HEAD) begin
      cur_q <= '0;
    end else if (cmd_i.rd == RD_ADV) begin
      cur_q <= rd_idx;
    end else if (cmd_i.rd == RD_B) begin
      idx_b_q <= rd_idx;
    end
    if (cmd_i.latch_a) begin
      a_q <= rd_word;
    end else if (cmd_i.adv) begin
      a_q <= b_q;
    end else if (cmd_i.wr == WR_MERGE) begin
      a_q <= wr_data;
    end
    if (cmd_i.adv) begin
      cur_q <= idx_b_q;
    end
    if (cmd_i.latch_b) begin
      b_q <= rd_word;
    end
    if (cmd_i.wr == WR_SPLIT) begin
      sp_q <= spare_idx;
    end
    if (cmd_i.cap_addr) begin
      pend_addr_q <= a_payload;
    end
    if (cmd_i.out_load) begin
      out_addr_q <= pend_addr_q;
    end
  end

  assign payload_address_o = out_addr_q;

  `FFHA_ASSERT(a_split_has_spare, (cmd_i.wr == WR_SPLIT) |-> spare_ok)
  `FFHA_ASSERT(a_push_in_bounds, (cmd_i.wr == WR_MERGE) |-> (stk_cnt_q < END_MARK))
  `FFHA_ASSERT_NOW(a_hwm_in_bounds, hwm_q <= END_MARK)

endmodule

FILE: sv/ffha_ctrl.sv
`include "assert_macros.svh"

module ffha_ctrl import ffha_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  logic               req_type_i,
  input  logic [BYTES_W-1:0] alloc_bytes_i,
  input  logic [ADDR_W-1:0]  free_address_i,
  output logic               rsp_valid_o,
  input  logic               rsp_ready_i,
  output logic [STAT_W-1:0]  status_o,
  input  ffha_sts_t          sts_i,
  output ffha_cmd_t          cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LATCH  = 4'd1;
  localparam logic [3:0] S_EVAL   = 4'd2;
  localparam logic [3:0] S_WSPLIT = 4'd3;
  localparam logic [3:0] S_MHEAD  = 4'd4;
  localparam logic [3:0] S_MLA    = 4'd5;
  localparam logic [3:0] S_MCHK   = 4'd6;
  localparam logic [3:0] S_MLB    = 4'd7;
  localparam logic [3:0] S_MEVAL  = 4'd8;
  localparam logic [3:0] S_FIN    = 4'd9;

  logic [3:0]        state_q, state_d;
  logic              op_q, op_d;
  logic [STAT_W-1:0] pend_q, pend_d;
  logic              out_valid_q, out_valid_d;
  logic [STAT_W-1:0] status_q, status_d;
  logic              accept, zero_req;

  assign req_ready_o = state_q == S_IDLE;
  assign accept      = req_valid_i && req_ready_o;
  assign zero_req    = (req_type_i == REQ_ALLOC) ? (alloc_bytes_i == '0)
                                                 : (free_address_i == '0);
  assign rsp_valid_o = out_valid_q;
  assign status_o    = status_q;

  // Sequence the list walk, the split and the merge pass
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q && !rsp_ready_i;
    status_d    = status_q;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          op_d       = req_type_i;
          if (zero_req) begin
            pend_d  = ST_ZERO;
            state_d = S_FIN;
          end else begin
            cmd_o.rd = RD_HEAD;
            state_d  = S_LATCH;
          end
        end
      end
      S_LATCH: begin
        cmd_o.latch_a = 1'b1;
        state_d       = S_EVAL;
      end
      S_EVAL: begin
        if (op_q == REQ_ALLOC) begin
          if (sts_i.a_free && sts_i.a_fits) begin
            pend_d = ST_OK;
            if (sts_i.split_ok) begin
              cmd_o.wr = WR_SPLIT;
              state_d  = S_WSPLIT;
            end else begin
              cmd_o.wr       = WR_GRANT;
              cmd_o.cap_addr = 1'b1;
              state_d        = S_FIN;
            end
          end else if (sts_i.a_last) begin
            pend_d  = ST_OOM;
            state_d = S_FIN;
          end else begin
            cmd_o.rd = RD_ADV;
            state_d  = S_LATCH;
          end
        end else begin
          if (sts_i.match) begin
            pend_d   = ST_OK;
            cmd_o.wr = WR_FREE;
            state_d  = S_MHEAD;
          end else if (sts_i.a_last) begin
            pend_d  = ST_UNKNOWN;
            state_d = S_FIN;
          end else begin
            cmd_o.rd = RD_ADV;
            state_d  = S_LATCH;
          end
        end
      end
      S_WSPLIT: begin
        cmd_o.wr       = WR_A_SPLIT;
        cmd_o.cap_addr = 1'b1;
        state_d        = S_FIN;
      end
      S_MHEAD: begin
        cmd_o.rd = RD_HEAD;
        state_d  = S_MLA;
      end
      S_MLA: begin
        cmd_o.latch_a = 1'b1;
        state_d       = S_MCHK;
      end
      S_MCHK: begin
        if (sts_i.a_last) begin
          state_d = S_FIN;
        end else begin
          cmd_o.rd = RD_B;
          state_d  = S_MLB;
        end
      end
      S_MLB: begin
        cmd_o.latch_b = 1'b1;
        state_d       = S_MEVAL;
      end
      S_MEVAL: begin
        // Fold a free neighbor into the current block when both are free, else step on
        if (sts_i.a_free && sts_i.b_free) begin
          cmd_o.wr = WR_MERGE;
        end else begin
          cmd_o.adv = 1'b1;
        end
        state_d = S_MCHK;
      end
      S_FIN: begin
        // Hold until the output register is free
        if (!out_valid_q || rsp_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          status_d       = pend_q;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    pend_q   <= pend_d;
    status_q <= status_d;
  end

  `FFHA_ASSERT(a_accept_leaves_idle, accept |=> (state_q != S_IDLE))
  `FFHA_ASSERT(a_fin_waits, (state_q == S_FIN && out_valid_q && !rsp_ready_i) |=> (state_q == S_FIN))
  `FFHA_ASSERT_NOW(a_one_table_op, (cmd_o.wr == WR_NONE) || (cmd_o.rd == RD_NONE))

endmodule

FILE: sv/first_fit_heap_allocator.sv
// Channel   Role     Payload
// req_i     sink     req_type, alloc_bytes, free_address
// rsp_o     source   status, payload_address
// APB       target   heap_base at byte 0x0 (64-bit data)
//
// A request walks the block list, latching then evaluating each block, paced by
// the registered read of the single block table. A free adds a merge pass over
// the list, stepping MCHK, MLB, MEVAL per block. Zero requests skip to FIN.
// Reset is asynchronous and needs no clearing pass; the arena is one free
// block right after reset. A new request is taken while a result waits on rsp_o.
module first_fit_heap_allocator import ffha_pkg::*; #(
  parameter int HEAP_BYTES   = 4194304,
  parameter int MAX_BLOCKS   = 256,
  parameter int HEADER_BYTES = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  ffha_req_if.sink           req_i,
  ffha_rsp_if.source         rsp_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [CFG_W-1:0]   pwdata,
  output logic [CFG_W-1:0]   prdata,
  output logic               pready
);

  logic [ADDR_W-1:0] heap_base_q;
  ffha_cmd_t         cmd;
  ffha_sts_t         sts;

  // Config register
  assign pready = 1'b1;
  assign prdata = (paddr[3] == REG_HEAP_BASE) ? CFG_W'(heap_base_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[3] == REG_HEAP_BASE)) begin
      heap_base_q <= pwdata[ADDR_W-1:0];
    end
  end

  ffha_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (req_i.valid),
    .req_ready_o    (req_i.ready),
    .req_type_i     (req_i.req_type),
    .alloc_bytes_i  (req_i.alloc_bytes),
    .free_address_i (req_i.free_address),
    .rsp_valid_o    (rsp_o.valid),
    .rsp_ready_i    (rsp_o.ready),
    .status_o       (rsp_o.status),
    .sts_i          (sts),
    .cmd_o          (cmd)
  );

  ffha_dp #(
    .HEAP_BYTES   (HEAP_BYTES),
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .heap_base_i       (heap_base_q),
    .alloc_bytes_i     (req_i.alloc_bytes),
    .free_address_i    (req_i.free_address),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .payload_address_o (rsp_o.payload_address)
  );

endmodule
